// ----- sv/utv_pkg.sv -----
package utv_pkg;

	localparam int UTV_MAX_LENGTH = 32;
	localparam int UTV_QDEPTH     = 2;
	localparam int UTV_POS_W      = 6;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_Z     = 8'h5A;

	localparam logic [UTV_POS_W-1:0] POS_SHORT    = 6'd19;
	localparam logic [UTV_POS_W-1:0] POS_MIN_FRAC = 6'd21;
	localparam logic [UTV_POS_W-1:0] POS_SAT      = 6'd63;

	localparam logic [6:0] HOUR_MAX   = 7'd23;
	localparam logic [6:0] MINUTE_MAX = 7'd59;
	localparam logic [6:0] SECOND_MAX = 7'd60;
	localparam logic [6:0] MONTH_MAX  = 7'd12;

	// one finished string: layout flag plus the decoded fields
	typedef struct packed {
		logic        err;
		logic [13:0] year;
		logic [4:0]  year_mod25;
		logic [6:0]  month;
		logic [6:0]  day;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
	} utv_rec_t;

	// days in month, month 1..12; zero for anything else
	function automatic logic [4:0] month_length(input logic leap, input logic [6:0] month);
		logic [4:0] len;
		unique case (month)
			7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
			7'd4, 7'd6, 7'd9, 7'd11:                    len = 5'd30;
			7'd2:                                       len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

// ----- sv/utv_front.sv -----
module utv_front import utv_pkg::*; #(
	parameter int MAX_LENGTH = UTV_MAX_LENGTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_byte
	input  logic       s_tlast,   // last_char
	input  logic       q_full,
	output logic       q_push,
	output utv_rec_t   q_rec
);

	typedef enum logic [3:0] {
		CL_YEAR, CL_MONTH, CL_DAY, CL_HOUR, CL_MINUTE, CL_SECOND,
		CL_DASH, CL_T, CL_COLON, CL_SEP19, CL_TAIL
	} cls_t;

	// 10*r mod 25 for r in 0..24
	localparam logic [4:0] X10MOD25 [25] = '{
		5'd0, 5'd10, 5'd20, 5'd5, 5'd15, 5'd0, 5'd10, 5'd20, 5'd5, 5'd15,
		5'd0, 5'd10, 5'd20, 5'd5, 5'd15, 5'd0, 5'd10, 5'd20, 5'd5, 5'd15,
		5'd0, 5'd10, 5'd20, 5'd5, 5'd15
	};

	logic [UTV_POS_W-1:0] pos_q;
	logic                 err_q;
	logic [13:0]          year_q;
	logic [4:0]           y25_q;
	logic [6:0]           month_q, day_q, hour_q, minute_q, second_q;

	logic                 accept;
	logic [7:0]           d8;
	logic [3:0]           dig;
	logic                 is_dig;
	cls_t                 cls;
	logic                 err_now;
	logic [5:0]           y25_sum;
	logic [4:0]           y25_nx;
	logic [13:0]          year_nx;
	logic [6:0]           month_nx, day_nx, hour_nx, minute_nx, second_nx;

	function automatic logic [6:0] acc7(input logic [6:0] acc, input logic [3:0] d);
		return 7'({acc, 3'b000} + {acc, 1'b0} + {3'b000, d});
	endfunction

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign q_push   = accept && s_tlast;

	always_comb begin
		d8     = s_tdata - CH_ZERO;
		dig    = d8[3:0];
		is_dig = (s_tdata >= CH_ZERO) && (s_tdata <= CH_ZERO + 8'd9);

		unique case (pos_q)
			6'd0, 6'd1, 6'd2, 6'd3: cls = CL_YEAR;
			6'd4, 6'd7:             cls = CL_DASH;
			6'd5, 6'd6:             cls = CL_MONTH;
			6'd8, 6'd9:             cls = CL_DAY;
			6'd10:                  cls = CL_T;
			6'd11, 6'd12:           cls = CL_HOUR;
			6'd13, 6'd16:           cls = CL_COLON;
			6'd14, 6'd15:           cls = CL_MINUTE;
			6'd17, 6'd18:           cls = CL_SECOND;
			6'd19:                  cls = CL_SEP19;
			default:                cls = CL_TAIL;
		endcase

		err_now = (pos_q >= UTV_POS_W'(MAX_LENGTH)) || (s_tlast && pos_q < POS_SHORT);
		unique case (cls)
			CL_DASH:  err_now = err_now || (s_tdata != CH_DASH);
			CL_T:     err_now = err_now || (s_tdata != CH_T);
			CL_COLON: err_now = err_now || (s_tdata != CH_COLON);
			CL_SEP19: err_now = err_now || (s_tdata != (s_tlast ? CH_Z : CH_DOT));
			CL_TAIL: begin
				if (s_tlast)
					err_now = err_now || (s_tdata != CH_Z) || (pos_q < POS_MIN_FRAC);
				else
					err_now = err_now || !is_dig;
			end
			default:  err_now = err_now || !is_dig;
		endcase

		// year mod 25 rides along for the century rule
		y25_sum = {1'b0, X10MOD25[y25_q]} + {2'b00, dig};
		y25_nx  = (y25_sum >= 6'd25) ? 5'(y25_sum - 6'd25) : y25_sum[4:0];

		year_nx   = year_q;
		month_nx  = month_q;
		day_nx    = day_q;
		hour_nx   = hour_q;
		minute_nx = minute_q;
		second_nx = second_q;
		if (!is_dig)
			y25_nx = y25_q;
		else begin
			unique case (cls)
				CL_YEAR:   year_nx   = 14'({year_q, 3'b000} + {year_q, 1'b0} + {10'd0, dig});
				CL_MONTH:  month_nx  = acc7(month_q, dig);
				CL_DAY:    day_nx    = acc7(day_q, dig);
				CL_HOUR:   hour_nx   = acc7(hour_q, dig);
				CL_MINUTE: minute_nx = acc7(minute_q, dig);
				CL_SECOND: second_nx = acc7(second_q, dig);
				default: ;
			endcase
			if (cls != CL_YEAR)
				y25_nx = y25_q;
		end
	end

	always_comb begin
		q_rec.err        = err_q || err_now;
		q_rec.year       = year_q;
		q_rec.year_mod25 = y25_q;
		q_rec.month      = month_q;
		q_rec.day        = day_q;
		q_rec.hour       = hour_q;
		q_rec.minute     = minute_q;
		q_rec.second     = second_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			err_q    <= 1'b0;
			year_q   <= '0;
			y25_q    <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
		end else if (accept) begin
			if (s_tlast) begin
				// string done: back to the start
				pos_q    <= '0;
				err_q    <= 1'b0;
				year_q   <= '0;
				y25_q    <= '0;
				month_q  <= '0;
				day_q    <= '0;
				hour_q   <= '0;
				minute_q <= '0;
				second_q <= '0;
			end else begin
				if (pos_q != POS_SAT)
					pos_q <= pos_q + 6'd1;
				err_q    <= err_q || err_now;
				year_q   <= year_nx;
				y25_q    <= y25_nx;
				month_q  <= month_nx;
				day_q    <= day_nx;
				hour_q   <= hour_nx;
				minute_q <= minute_nx;
				second_q <= second_nx;
			end
		end
	end

endmodule

// ----- sv/utv_queue.sv -----
module utv_queue import utv_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  utv_rec_t push_rec,
	output logic     full,
	input  logic     pop,
	output logic     q_valid,
	output utv_rec_t q_rec
);

	localparam int PTR_W = (UTV_QDEPTH > 1) ? $clog2(UTV_QDEPTH) : 1;
	localparam int CNT_W = $clog2(UTV_QDEPTH + 1);

	utv_rec_t         mem_q [UTV_QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CNT_W'(UTV_QDEPTH));
	assign q_valid = (count_q != '0);
	assign q_rec   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && q_valid;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(UTV_QDEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ----- sv/utv_back.sv -----
module utv_back import utv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	input  utv_rec_t   q_rec,
	output logic       q_pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [0] accepted, [7:1] zero
);

	logic       valid_q;
	logic       acc_q;
	logic       leap;
	logic [4:0] mlen;
	logic       ok;

	// take the next record whenever the output slot frees up this cycle
	assign q_pop    = q_valid && (!valid_q || m_tready);
	assign m_tvalid = valid_q;
	assign m_tdata  = {7'd0, acc_q};

	always_comb begin
		// divisible by 4, and not by 100 unless by 400
		leap = (q_rec.year[1:0] == 2'b00) &&
		       ((q_rec.year_mod25 != 5'd0) || (q_rec.year[3:0] == 4'd0));
		mlen = month_length(leap, q_rec.month);
		ok   = !q_rec.err && (q_rec.year != '0) &&
		       (q_rec.month >= 7'd1) && (q_rec.month <= MONTH_MAX) &&
		       (q_rec.day >= 7'd1) && (q_rec.day <= {2'b00, mlen}) &&
		       (q_rec.hour <= HOUR_MAX) && (q_rec.minute <= MINUTE_MAX) &&
		       (q_rec.second <= SECOND_MAX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (q_pop)
			valid_q <= 1'b1;
		else if (m_tready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			acc_q <= ok;
	end

endmodule

// ----- sv/utc_timestamp_validator_unit.sv -----
// Takes one character per cycle; s_tready drops only while the two-entry result queue
// is full, which happens only when m_tready holds results back.
// Path: the final character's result is written into a queue entry when taken, and
// the output register loads it from the queue once the output slot is free.
// Throughput: one character per cycle while s_tready is high; one result per string.
// Reset (arst_n low, asynchronous): position, error flag and accumulators clear,
// the result queue empties and m_tvalid drops.
module utc_timestamp_validator_unit import utv_pkg::*; #(
	parameter int MAX_LENGTH = UTV_MAX_LENGTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_byte
	input  logic       s_tlast,   // last_char
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata    // [0] accepted, [7:1] zero
);

	utv_rec_t push_rec, pop_rec;
	logic     q_full, q_push, q_pop, q_valid;

	utv_front #(.MAX_LENGTH(MAX_LENGTH)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_rec    (push_rec)
	);

	utv_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_rec (push_rec),
		.full     (q_full),
		.pop      (q_pop),
		.q_valid  (q_valid),
		.q_rec    (pop_rec)
	);

	utv_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_rec    (pop_rec),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ----- tb/sv/tb_utc_timestamp_validator_unit.sv -----
module tb_utc_timestamp_validator_unit;
	import utv_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_CHARS = 1750;
	localparam int IDLE_LIMIT   = 2000;
	localparam int TAIL_CYCLES  = 10;

	typedef logic [7:0] text_t[$];

	typedef struct {
		logic [7:0] ch;
		logic       fin;
		bit         drain;
	} char_req_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = '0;   // [7:0] char_byte
	logic       s_tlast = 1'b0; // last_char
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;        // [0] accepted, [7:1] zero

	utc_timestamp_validator_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// request stream and expected verdicts
	char_req_t char_q[$];
	logic      verdict_q[$];
	int        expected_total = 0;  // written with NBA so both sides see a stable count
	int        checked_total  = 0;
	int        chars_taken    = 0;
	int        results_seen   = 0;
	int        accepted_seen  = 0;
	int        drains_done    = 0;
	int        fails          = 0;
	int        send_gap       = 0;
	int        recv_stall     = 0;
	int        planned_chars  = 0;

	// timestamp tracker state
	logic [5:0]  st_pos;
	logic        st_err;
	logic [13:0] st_year;
	logic [6:0]  st_month, st_day, st_hour, st_minute, st_second;

	function automatic int days_in(input int y, input int m);
		logic leap_year;
		leap_year = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
		case (m)
			2:                     return leap_year ? 29 : 28;
			4, 6, 9, 11:           return 30;
			1, 3, 5, 7, 8, 10, 12: return 31;
			default:               return 0;
		endcase
	endfunction

	function automatic logic is_dec(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_ZERO + 8'd9;
	endfunction

	function automatic void clear_stamp();
		st_pos    = '0;
		st_err    = 1'b0;
		st_year   = '0;
		st_month  = '0;
		st_day    = '0;
		st_hour   = '0;
		st_minute = '0;
		st_second = '0;
	endfunction

	// advance the tracker by one character; returns 1 when a verdict is due
	function automatic bit track_char(input logic [7:0] c, input logic fin,
			output logic verdict);
		int         p;
		logic       bad;
		logic [7:0] d;
		int         mlen;
		p = st_pos;
		bad = (p >= UTV_MAX_LENGTH);
		d = c - CH_ZERO;
		verdict = 1'b0;
		case (p)
			4, 7:   bad |= (c != CH_DASH);
			10:     bad |= (c != CH_T);
			13, 16: bad |= (c != CH_COLON);
			0, 1, 2, 3: begin
				if (is_dec(c)) st_year = st_year * 10 + d; else bad = 1'b1;
			end
			5, 6: begin
				if (is_dec(c)) st_month = st_month * 10 + d; else bad = 1'b1;
			end
			8, 9: begin
				if (is_dec(c)) st_day = st_day * 10 + d; else bad = 1'b1;
			end
			11, 12: begin
				if (is_dec(c)) st_hour = st_hour * 10 + d; else bad = 1'b1;
			end
			14, 15: begin
				if (is_dec(c)) st_minute = st_minute * 10 + d; else bad = 1'b1;
			end
			17, 18: begin
				if (is_dec(c)) st_second = st_second * 10 + d; else bad = 1'b1;
			end
			POS_SHORT: bad |= (c != (fin ? CH_Z : CH_DOT));
			default: begin
				if (fin)
					bad |= (c != CH_Z) || (p < POS_MIN_FRAC);
				else
					bad |= !is_dec(c);
			end
		endcase
		if (fin && p < POS_SHORT)
			bad = 1'b1;
		if (bad)
			st_err = 1'b1;
		if (st_pos != POS_SAT)
			st_pos++;
		if (!fin)
			return 0;
		mlen = days_in(st_year, st_month);
		verdict = !st_err && st_year != 0 && st_month >= 1 && st_month <= MONTH_MAX
			&& st_day >= 1 && st_day <= mlen && st_hour <= HOUR_MAX
			&& st_minute <= MINUTE_MAX && st_second <= SECOND_MAX;
		clear_stamp();
		return 1;
	endfunction

	task automatic add_text(input text_t t);
		for (int i = 0; i < t.size(); i++)
			char_q.push_back('{ch: t[i], fin: (i == t.size() - 1), drain: 1'b0});
		planned_chars += t.size();
	endtask

	task automatic add_str(input string s);
		text_t t;
		for (int i = 0; i < s.len(); i++)
			t.push_back(s[i]);
		add_text(t);
	endtask

	task automatic add_drain();
		char_q.push_back('{ch: 8'h00, fin: 1'b0, drain: 1'b1});
	endtask

	task automatic put_num(ref text_t t, input int v, input int n);
		int div;
		div = 1;
		repeat (n - 1) div *= 10;
		repeat (n) begin
			t.push_back(CH_ZERO + 8'((v / div) % 10));
			div /= 10;
		end
	endtask

	task automatic build_stamp(ref text_t t, input int y, input int mo, input int d,
			input int h, input int mi, input int s, input int frac);
		t.delete();
		put_num(t, y, 4);
		t.push_back(CH_DASH);
		put_num(t, mo, 2);
		t.push_back(CH_DASH);
		put_num(t, d, 2);
		t.push_back(CH_T);
		put_num(t, h, 2);
		t.push_back(CH_COLON);
		put_num(t, mi, 2);
		t.push_back(CH_COLON);
		put_num(t, s, 2);
		if (frac > 0) begin
			t.push_back(CH_DOT);
			repeat (frac) t.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
		end
		t.push_back(CH_Z);
	endtask

	task automatic random_stamp(ref text_t t);
		int y, mo, d, h, mi, s, frac, mlen;
		case ($urandom_range(0, 3))
			0:       y = $urandom_range(0, 9999);
			1:       y = $urandom_range(0, 99) * 100;
			2:       y = $urandom_range(0, 2499) * 4;
			default: y = $urandom_range(1, 9999);
		endcase
		mo = ($urandom_range(0, 9) != 0) ? $urandom_range(1, 12) : $urandom_range(0, 99);
		mlen = days_in(y, mo);
		case ($urandom_range(0, 3))
			0, 1:    d = $urandom_range(1, 28);
			2:       d = $urandom_range(mlen > 1 ? mlen - 1 : 0, mlen + 1);
			default: d = $urandom_range(0, 99);
		endcase
		h  = ($urandom_range(0, 7) != 0) ? $urandom_range(0, 23) : $urandom_range(0, 99);
		mi = ($urandom_range(0, 7) != 0) ? $urandom_range(0, 59) : $urandom_range(0, 99);
		s  = ($urandom_range(0, 7) != 0) ? $urandom_range(0, 60) : $urandom_range(0, 99);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: frac = 0;
			9:             frac = $urandom_range(1, 45);
			default:       frac = $urandom_range(1, UTV_MAX_LENGTH - 21);
		endcase
		build_stamp(t, y, mo, d, h, mi, s, frac);
	endtask

	// sender: hold the request until taken, then wait a drawn gap
	always @(posedge clk or negedge arst_n) begin : sender
		char_req_t item;
		logic      verdict;
		logic      busy;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
			send_gap = 0;
		end else begin
			busy = s_tvalid && !s_tready;
			if (s_tvalid && s_tready) begin
				chars_taken++;
				if (track_char(s_tdata, s_tlast, verdict)) begin
					verdict_q.push_back(verdict);
					expected_total <= expected_total + 1;
				end
				send_gap = ((chars_taken / 300) % 4 == 3) ? 0 : $urandom_range(0, 8);
			end
			if (!busy) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (char_q.size() != 0 && char_q[0].drain) begin
					// hold off until every pending verdict has come back
					if (expected_total == checked_total && !(s_tvalid && s_tready)) begin
						void'(char_q.pop_front());
						drains_done++;
					end
					s_tvalid <= 1'b0;
				end else if (char_q.size() != 0) begin
					item = char_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= item.ch;
					s_tlast  <= item.fin;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: compare each verdict, then stall for a drawn count
	always @(posedge clk or negedge arst_n) begin : receiver
		logic want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_stall = 0;
			checked_total <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (checked_total == expected_total) begin
					$error("accepted: no verdict pending, got %0b", m_tdata[0]);
					fails++;
				end else begin
					want = verdict_q.pop_front();
					if (m_tdata[0] !== want) begin
						$error("accepted: expected %0b, got %0b", want, m_tdata[0]);
						fails++;
					end
					if (m_tdata[7:1] !== 7'd0) begin
						$error("pad: expected 0, got %0h", m_tdata[7:1]);
						fails++;
					end
					checked_total <= checked_total + 1;
				end
				if (m_tdata[0] === 1'b1)
					accepted_seen++;
				recv_stall = ((results_seen / 6) % 4 == 2) ? 0 : $urandom_range(0, 8);
			end
			if (recv_stall > 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		int idle;
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle = 0;
		end else begin
			idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("timeout after %0d idle cycles", idle);
				$display("tb_utc_timestamp_validator_unit NOT OK");
				$finish;
			end
		end
	end

	initial begin : stimulus
		text_t t;
		int    strings_made;
		clear_stamp();

		add_str("0001-01-01T00:00:00Z");
		add_str("9999-12-31T23:59:60Z");
		add_str("2000-02-29T12:30:45Z");
		add_str("1900-02-29T12:30:45Z");
		add_str("2023-02-29T00:00:00Z");
		add_str("2024-02-29T00:00:00.5Z");
		add_str("0000-06-15T10:10:10Z");
		add_str("2021-00-10T10:10:10Z");
		add_str("2021-13-10T10:10:10Z");
		add_str("2021-04-31T10:10:10Z");
		add_str("2021-04-00T10:10:10Z");
		add_str("2021-05-05T24:00:00Z");
		add_str("2021-05-05T23:60:00Z");
		add_str("2021-05-05T23:59:61Z");
		add_str("2021-05-05T10:10:10.Z");
		add_str("2021-05-05T10:10:10.12345678901Z");
		add_str("2021-05-05T10:10:10.123456789012Z");
		add_str("2021-05-05T10:10:10");
		add_str("Z");
		add_str("2021-05-05T10:10:10X");
		add_str("2021-05-05T10:10:10Z5Z");
		add_str("2021-05-05T10:10:10.123");
		add_str("2021-05-05 10:10:10Z");
		add_str("2021-0A-05T10:10:10.12a4Z");
		// run past the saturation point of the position counter
		build_stamp(t, 2020, 1, 1, 0, 0, 0, 49);
		add_text(t);
		build_stamp(t, 2021, 5, 5, 10, 10, 10, 0);
		t[2] = 8'hFF;
		t[4] = 8'h00;
		add_text(t);
		add_drain();

		strings_made = 0;
		while (planned_chars < RANDOM_CHARS) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: random_stamp(t);
				12, 13, 14, 15, 16: begin
					random_stamp(t);
					case ($urandom_range(0, 3))
						0: t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(0, 255));
						1: begin
							int keep;
							keep = $urandom_range(1, t.size() - 1);
							while (t.size() > keep) void'(t.pop_back());
						end
						2: repeat ($urandom_range(1, 40))
							t.insert(t.size() - 1, CH_ZERO + 8'($urandom_range(0, 9)));
						default: t[t.size() - 1] = ($urandom_range(0, 1) != 0) ? CH_DOT
							: CH_ZERO + 8'($urandom_range(0, 9));
					endcase
				end
				default: begin
					t.delete();
					repeat ($urandom_range(1, 70)) t.push_back(8'($urandom_range(0, 255)));
					if ($urandom_range(0, 1) != 0)
						t[t.size() - 1] = CH_Z;
				end
			endcase
			add_text(t);
			strings_made++;
			if (strings_made % 15 == 0)
				add_drain();
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (char_q.size() != 0 || s_tvalid || expected_total != checked_total)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (verdict_q.size() != 0) begin
			$error("%0d verdicts never arrived", verdict_q.size());
			fails++;
		end
		$display("sent %0d characters, checked %0d verdicts (%0d accepted, %0d rejected)",
			chars_taken, checked_total, accepted_seen, checked_total - accepted_seen);
		$display("covered leap years, field limits, length bounds, noise; %0d full drains",
			drains_done);
		if (fails == 0) begin
			$display("tb_utc_timestamp_validator_unit OK");
		end else begin
			$display("tb_utc_timestamp_validator_unit NOT OK");
		end
		$finish;
	end

endmodule

// ----- files.f -----
sv/utv_pkg.sv
sv/utv_front.sv
sv/utv_queue.sv
sv/utv_back.sv
sv/utc_timestamp_validator_unit.sv
tb/sv/tb_utc_timestamp_validator_unit.sv
